/* sv/u8s_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types and constants for the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned LIT_MAX     = 4;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [1:0] PH_B0 = 2'd0;
  localparam logic [1:0] PH_B1 = 2'd1;
  localparam logic [1:0] PH_B2 = 2'd2;

  // sequence lengths from the lead byte
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  // one command: r1 replacements, lit_n literal bytes, r2 replacements
  typedef struct packed {
    logic [1:0]                r1;
    logic [2:0]                lit_n;
    logic [LIT_MAX-1:0][7:0]   lit;
    logic [1:0]                r2;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] ph);
    logic [7:0] b;
    case (ph)
      PH_B0:   b = REPL_B0;
      PH_B1:   b = REPL_B1;
      PH_B2:   b = REPL_B2;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = LEN_1;
    end else if (b[7:5] == 3'b110) begin
      len = LEN_2;
    end else if (b[7:4] == 4'b1110) begin
      len = LEN_3;
    end else if (b[7:3] == 5'b11110) begin
      len = LEN_4;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

endpackage

/* sv/u8s_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8s_front
// Accepts input words, tracks the held sequence and issues one command per
// word that yields output.
// ----------------------------------------------------------------------------
module u8s_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          q_push,
  output u8s_pkg::cmd_t q_cmd
);
  import u8s_pkg::*;

  logic [2:0][7:0] held_r;
  logic [2:0][7:0] held_nxt;
  logic [1:0]      held_cnt_r;
  logic [1:0]      held_cnt_nxt;
  logic [2:0]      exp_len_r;
  logic [2:0]      exp_len_nxt;

  logic       acc;
  logic       cont;
  logic       brk;
  logic [1:0] hc;
  logic [2:0] len;
  logic       mid_repl;
  cmd_t       cmd;

  assign acc  = in_tvalid & in_tready;
  assign cont = (in_byte[7:6] == 2'b10);
  assign brk  = (held_cnt_r != 2'd0) & ~cont;
  assign hc   = brk ? 2'd0 : held_cnt_r;
  assign len  = lead_len(in_byte);

  always_comb begin
    held_nxt     = held_r;
    held_cnt_nxt = hc;
    exp_len_nxt  = brk ? 3'd0 : exp_len_r;
    mid_repl     = 1'b0;
    cmd.r1       = brk ? held_cnt_r : 2'd0;
    cmd.lit_n    = 3'd0;
    cmd.lit      = '0;
    cmd.r2       = 2'd0;
    cmd.last     = in_last;
    if (hc == 2'd0) begin
      if (len == LEN_1) begin
        cmd.lit_n  = 3'd1;
        cmd.lit[0] = in_byte;
      end else if (len == LEN_BAD) begin
        mid_repl = 1'b1;
      end else begin
        held_nxt[0]  = in_byte;
        held_cnt_nxt = 2'd1;
        exp_len_nxt  = len;
      end
    end else if (({1'b0, hc} + 3'd1) >= exp_len_r) begin
      cmd.lit_n    = {1'b0, hc} + 3'd1;
      cmd.lit[0]   = held_r[0];
      cmd.lit[1]   = (hc == 2'd1) ? in_byte : held_r[1];
      cmd.lit[2]   = (hc == 2'd2) ? in_byte : held_r[2];
      cmd.lit[3]   = in_byte;
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end else begin
      held_nxt[hc] = in_byte;
      held_cnt_nxt = hc + 2'd1;
    end
    cmd.r2 = {1'b0, mid_repl};
    if (in_last) begin
      cmd.r2       = held_cnt_nxt | {1'b0, mid_repl};
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = acc & ((cmd.r1 != 2'd0) | (cmd.lit_n != 3'd0) | (cmd.r2 != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      exp_len_r  <= 3'd0;
    end else if (acc) begin
      held_cnt_r <= held_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

/* sv/u8s_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8s_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8s_cmd_fifo #(
  parameter int unsigned DEPTH = u8s_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8s_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output u8s_pkg::cmd_t    head,
  output u8s_pkg::q_stat_t stat
);
  import u8s_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/u8s_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8s_back
// Expands the head command into output words, one per cycle unless out_tready
// holds them, through an output register.
// ----------------------------------------------------------------------------
module u8s_back (
  input  logic             clk,
  input  logic             rst_n,
  input  u8s_pkg::cmd_t    head,
  input  u8s_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_stream_end
);
  import u8s_pkg::*;

  logic [1:0] a_cnt_r, a_cnt_nxt;
  logic [2:0] l_cnt_r, l_cnt_nxt;
  logic [1:0] b_cnt_r, b_cnt_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       run_last_r;
  logic       end_r;

  logic       load;
  logic       in_a;
  logic       in_l;
  logic       unit_end;
  logic       fin;
  logic [7:0] byte_c;

  assign load = ~stat.empty & (~vld_r | out_tready);
  assign in_a = ({1'b0, a_cnt_r} < {1'b0, head.r1});
  assign in_l = ~in_a & (l_cnt_r < head.lit_n);
  assign unit_end = in_l | (ph_r == PH_B2);

  always_comb begin
    byte_c = in_l ? head.lit[l_cnt_r[1:0]] : repl_byte(ph_r);
    if (in_a) begin
      fin = (ph_r == PH_B2) & (({1'b0, a_cnt_r} + 3'd1) == {1'b0, head.r1})
          & (head.lit_n == 3'd0) & (head.r2 == 2'd0);
    end else if (in_l) begin
      fin = ((l_cnt_r + 3'd1) == head.lit_n) & (head.r2 == 2'd0);
    end else begin
      fin = (ph_r == PH_B2) & (({1'b0, b_cnt_r} + 3'd1) == {1'b0, head.r2});
    end
  end

  always_comb begin
    a_cnt_nxt = a_cnt_r;
    l_cnt_nxt = l_cnt_r;
    b_cnt_nxt = b_cnt_r;
    ph_nxt    = ph_r;
    if (fin) begin
      a_cnt_nxt = 2'd0;
      l_cnt_nxt = 3'd0;
      b_cnt_nxt = 2'd0;
      ph_nxt    = PH_B0;
    end else if (in_l) begin
      l_cnt_nxt = l_cnt_r + 3'd1;
    end else begin
      ph_nxt = unit_end ? PH_B0 : ph_r + 2'd1;
      if (unit_end && in_a) begin
        a_cnt_nxt = a_cnt_r + 2'd1;
      end else if (unit_end) begin
        b_cnt_nxt = b_cnt_r + 2'd1;
      end
    end
  end

  assign pop = load & fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= 2'd0;
      l_cnt_r <= 3'd0;
      b_cnt_r <= 2'd0;
      ph_r    <= PH_B0;
      vld_r   <= 1'b0;
    end else begin
      if (load) begin
        a_cnt_r <= a_cnt_nxt;
        l_cnt_r <= l_cnt_nxt;
        b_cnt_r <= b_cnt_nxt;
        ph_r    <= ph_nxt;
        vld_r   <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= byte_c;
      run_last_r <= fin;
      end_r      <= fin & head.last;
    end
  end

  assign out_tvalid     = vld_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_stream_end = end_r;

endmodule

/* sv/utf8_stream_sanitizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Passes well-formed UTF-8 and turns broken or stray bytes into EF BF BD.
// ----------------------------------------------------------------------------
//  channel   direction  tdata        tlast        tuser
//  in_       slave      in_byte      stream_last  -
//  out_      master     out_byte     run_last     stream_end
//
//  the back part sends one output word per cycle unless out_tready stalls,
//  so an input word yielding n bytes (1 to 12) holds its queue entry until
//  all are sent, and valid text runs at one byte per cycle without stalls
//  a lead byte alone sends nothing until its sequence ends
//  rst_n is synchronous and clears the held count, queue and output stage
//  in_tready drops only while the command queue is full
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] stream_end
);
  import u8s_pkg::*;

  logic    q_push;
  logic    q_pop;
  cmd_t    q_cmd;
  cmd_t    q_head;
  q_stat_t q_stat;

  assign in_tready = ~q_stat.full;

  u8s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  u8s_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  u8s_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .stat           (q_stat),
    .pop            (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .out_run_last   (out_tlast),
    .out_stream_end (out_tuser)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("stream end not on run end");

  a_pop_sends: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid && out_tlast)
    else $error("command finished without run end word");

endmodule

/* tb/utf8_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches both stream channels of the UTF-8 sanitizer, predicts the output
// bytes of every accepted input word and compares them in order with the
// words the block sends.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  input  logic       out_tuser,
  output int         fail_count,
  output int         pending,
  output int         in_words,
  output int         out_words,
  output int         repl_chars
);
  import u8s_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_word_t;

  out_word_t  expected_bytes[$];
  out_word_t  step_bytes[$];
  out_word_t  head;
  logic [7:0] held [3];
  logic [1:0] held_n = 2'd0;
  logic [2:0] seq_len = LEN_BAD;
  int         fails = 0;
  int         n_in = 0;
  int         n_out = 0;
  int         n_repl = 0;

  task add_byte(input logic [7:0] b);
    step_bytes.push_back('{b, 1'b0, 1'b0});
  endtask

  task add_repl;
    add_byte(REPL_B0);
    add_byte(REPL_B1);
    add_byte(REPL_B2);
    n_repl++;
  endtask

  task flush_held;
    repeat (held_n) add_repl();
    held_n  = 2'd0;
    seq_len = LEN_BAD;
  endtask

  task sanitize_word(input logic [7:0] b, input logic last);
    logic [2:0] len;
    int         k;
    step_bytes.delete();
    if (held_n != 2'd0 && b[7:6] != 2'b10) flush_held();
    if (held_n == 2'd0) begin
      casez (b)
        8'b0???????: len = LEN_1;
        8'b110?????: len = LEN_2;
        8'b1110????: len = LEN_3;
        8'b11110???: len = LEN_4;
        default:     len = LEN_BAD;
      endcase
      if (len == LEN_1) begin
        add_byte(b);
      end else if (len == LEN_BAD) begin
        add_repl();
      end else begin
        held[0] = b;
        held_n  = 2'd1;
        seq_len = len;
      end
    end else if (held_n + 1 >= seq_len) begin
      for (k = 0; k < held_n; k++) add_byte(held[k]);
      add_byte(b);
      held_n  = 2'd0;
      seq_len = LEN_BAD;
    end else begin
      held[held_n] = b;
      held_n       = held_n + 2'd1;
    end
    if (last) flush_held();
    if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size()-1].run_last   = 1'b1;
      step_bytes[step_bytes.size()-1].stream_end = last;
    end
    foreach (step_bytes[j]) expected_bytes.push_back(step_bytes[j]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bytes.delete();
      held_n  = 2'd0;
      seq_len = LEN_BAD;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected out word, expected none, got byte %02h last %0b end %0b",
                   $time, out_tdata, out_tlast, out_tuser);
          fails++;
        end else begin
          head = expected_bytes.pop_front();
          if (head !== {out_tdata, out_tlast, out_tuser}) begin
            $display("%0t: out word %0d expected byte %02h last %0b end %0b,",
                     $time, n_out, head.data, head.run_last, head.stream_end);
            $display("%0t: out word %0d got byte %02h last %0b end %0b",
                     $time, n_out, out_tdata, out_tlast, out_tuser);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_in++;
        sanitize_word(in_tdata, in_tlast);
      end
    end
    fail_count <= fails;
    pending    <= expected_bytes.size();
    in_words   <= n_in;
    out_words  <= n_out;
    repl_chars <= n_repl;
  end

endmodule

/* tb/tb_utf8_stream_sanitizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_sanitizer
// Feeds the sanitizer a directed set of byte sequences and then random
// streams of mostly well-formed UTF-8 with broken, stray and truncated
// sequences mixed in, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_utf8_stream_sanitizer;

  localparam int RANDOM_WORDS = 93;
  localparam int STALL_LIMIT  = 1000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int fail_count;
  int pending;
  int in_words;
  int out_words;
  int repl_chars;
  int sent = 0;
  int streams = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  // {stream_last, in_byte}
  logic [8:0] hand_words [27] = '{
    9'h000, 9'h07F,
    9'h0C0, 9'h080, 9'h0DF, 9'h0BF,
    9'h0E0, 9'h0A0, 9'h080,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0F8, 9'h0FF,
    9'h0E2, 9'h082, 9'h041,
    9'h0C3, 9'h0F0, 9'h09F, 9'h080, 9'h1FF,
    9'h1E2,
    9'h0C2, 9'h141
  };

  utf8_stream_sanitizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  utf8_stream_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending),
    .in_words  (in_words),
    .out_words (out_words),
    .repl_chars(repl_chars)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task send_word(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task send_stream;
    logic [7:0] text[$];
    int         kind;
    int         len;
    int         conts;
    int         k;
    text.delete();
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        text.push_back(8'($urandom_range(8'h00, 8'h7F)));
      end else if (kind < 18) begin
        len   = (kind < 11) ? 2 : (kind < 14) ? 3 : (kind < 16) ? 4 : $urandom_range(2, 4);
        conts = (kind < 16) ? len - 1 : $urandom_range(0, len - 2);
        case (len)
          2:       text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          3:       text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          default: text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        repeat (conts) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        text.push_back(8'($urandom_range(8'h00, 8'hFF)));
      end
    end
    for (k = 0; k < text.size(); k++) send_word(text[k], k == text.size() - 1);
    streams++;
  endtask

  // receiver side
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("utf8_stream_sanitizer: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (hand_words[i]) send_word(hand_words[i][7:0], hand_words[i][8]);
    in_tvalid <= 1'b0;
    drain();

    while (sent < $size(hand_words) + RANDOM_WORDS) begin
      if (sent > $size(hand_words) + RANDOM_WORDS * 3 / 4) quiet = 1'b1;
      send_stream();
      if (!quiet && $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        drain();
      end
    end
    in_tvalid <= 1'b0;
    drain();
    repeat (16) @(posedge clk);

    $display("covered %0d input words in %0d random streams plus directed extremes,",
             in_words, streams);
    $display("broken, stray and truncated sequences; %0d output words, %0d replacements",
             out_words, repl_chars);
    if (fail_count == 0) begin
      $display("utf8_stream_sanitizer: match");
    end else begin
      $display("utf8_stream_sanitizer: mismatch");
    end
    $finish;
  end

endmodule
